@@ sv/jsc_pkg.sv @@
package jsc_pkg;

  // Container kinds held on the nesting stack
  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_doc;
  } in_word_t;

  typedef struct packed {
    logic valid_res;
    logic depth_exceeded;
  } out_word_t;

  // Request from the parser to the stack
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic kind;
  } stack_op_t;

  // Stack status seen by the parser
  typedef struct packed {
    logic zero;
    logic one;
    logic full;
    logic top_kind;
  } stack_stat_t;

endpackage

@@ sv/jsc_stack.sv @@
module jsc_stack #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  jsc_pkg::stack_op_t  op,
  output jsc_pkg::stack_stat_t stat
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          nest_kinds [0:MAX_DEPTH-1];
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW:0]   below_wide;
  logic [AW-1:0] rd_idx;
  logic          top;
  logic          under;

  always_comb begin
    level_next = level;
    if (op.clear) begin
      level_next = '0;
    end else if (op.push) begin
      level_next = level + LW'(1);
    end else if (op.pop) begin
      level_next = level - LW'(1);
    end
  end

  // Prefetch the entry under the top for the level seen next cycle
  assign below_wide = {1'b0, level_next} - (LW+1)'(2);
  assign rd_idx = ({1'b0, level_next} >= (LW+1)'(2)) ? below_wide[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      nest_kinds[level[AW-1:0]] <= op.kind;
    end
    under <= nest_kinds[rd_idx];
  end

  // Top of stack lives in a register; a pop promotes the prefetched entry
  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      top <= op.kind;
    end else if (op.pop && !op.clear) begin
      top <= under;
    end
  end

  assign stat.zero     = (level == '0);
  assign stat.one      = (level == LW'(1));
  assign stat.full     = (level == LW'(MAX_DEPTH));
  assign stat.top_kind = top;

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (op.push && !op.clear) |-> !stat.full)
    else $error("push while stack full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (op.pop && !op.clear) |-> !stat.zero)
    else $error("pop while stack empty");
  a_push_xor_pop: assert property (@(posedge clk) disable iff (rst)
    !(op.push && op.pop))
    else $error("push and pop together");
  a_top_follows_push: assert property (@(posedge clk) disable iff (rst)
    (op.push && !op.clear) |=> (stat.top_kind == $past(op.kind)))
    else $error("top of stack lost pushed kind");
`endif

endmodule

@@ sv/jsc_parser.sv @@
module jsc_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  jsc_pkg::in_word_t    word,
  input  jsc_pkg::stack_stat_t stat,
  output jsc_pkg::stack_op_t   op,
  output logic                 res_valid,
  output jsc_pkg::out_word_t   res
);

  localparam logic [4:0] PH_VALUE     = 5'd0;
  localparam logic [4:0] PH_ARR_FIRST = 5'd1;
  localparam logic [4:0] PH_OBJ_FIRST = 5'd2;
  localparam logic [4:0] PH_KEY       = 5'd3;
  localparam logic [4:0] PH_COLON     = 5'd4;
  localparam logic [4:0] PH_AFTER     = 5'd5;
  localparam logic [4:0] PH_STR       = 5'd6;
  localparam logic [4:0] PH_STR_ESC   = 5'd7;
  localparam logic [4:0] PH_KEY_STR   = 5'd8;
  localparam logic [4:0] PH_KEY_ESC   = 5'd9;
  localparam logic [4:0] PH_LIT       = 5'd10;
  localparam logic [4:0] PH_NUM_SIGN  = 5'd11;
  localparam logic [4:0] PH_NUM_ZERO  = 5'd12;
  localparam logic [4:0] PH_NUM_INT   = 5'd13;
  localparam logic [4:0] PH_NUM_DOT   = 5'd14;
  localparam logic [4:0] PH_NUM_FRAC  = 5'd15;
  localparam logic [4:0] PH_NUM_E     = 5'd16;
  localparam logic [4:0] PH_NUM_ESIGN = 5'd17;
  localparam logic [4:0] PH_NUM_EXP   = 5'd18;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;
  localparam logic [1:0] LIT_NONE  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_CTRL   = 8'h20;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0a) || (ch == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_e(input logic [7:0] ch);
    return (ch == 8'h65) || (ch == 8'h45);
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    case ({kind, idx})
      {LIT_TRUE,  3'd0}: ch = "t";
      {LIT_TRUE,  3'd1}: ch = "r";
      {LIT_TRUE,  3'd2}: ch = "u";
      {LIT_TRUE,  3'd3}: ch = "e";
      {LIT_FALSE, 3'd0}: ch = "f";
      {LIT_FALSE, 3'd1}: ch = "a";
      {LIT_FALSE, 3'd2}: ch = "l";
      {LIT_FALSE, 3'd3}: ch = "s";
      {LIT_FALSE, 3'd4}: ch = "e";
      {LIT_NULL,  3'd0}: ch = "n";
      {LIT_NULL,  3'd1}: ch = "u";
      {LIT_NULL,  3'd2}: ch = "l";
      {LIT_NULL,  3'd3}: ch = "l";
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [4:0] phase, phase_next;
  logic [1:0] lit_kind, lit_kind_next;
  logic [2:0] lit_idx, lit_idx_next;
  logic       error_seen, error_seen_next;
  logic       overflow_seen, overflow_seen_next;

  logic [7:0] c;
  logic       sv;
  logic       av;
  logic       fl;
  logic       done_ph;
  logic       empty_after;

  assign c = word.data_byte;

  always_comb begin
    phase_next         = phase;
    lit_kind_next      = lit_kind;
    lit_idx_next       = lit_idx;
    error_seen_next    = error_seen;
    overflow_seen_next = overflow_seen;
    op                 = '0;
    op.kind            = jsc_pkg::KIND_ARRAY;
    sv                 = 1'b0;
    av                 = 1'b0;
    fl                 = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    done_ph            = 1'b0;
    empty_after        = 1'b0;

    if (take && word.has_byte && !error_seen) begin
      unique case (phase)
        PH_VALUE: sv = 1'b1;
        PH_ARR_FIRST: begin
          if (c == CH_RBRACK) begin
            op.pop     = 1'b1;
            phase_next = PH_AFTER;
          end else begin
            sv = 1'b1;
          end
        end
        PH_OBJ_FIRST, PH_KEY: begin
          if (!is_ws(c)) begin
            if (c == CH_RBRACE && phase == PH_OBJ_FIRST) begin
              op.pop     = 1'b1;
              phase_next = PH_AFTER;
            end else if (c == CH_QUOTE) begin
              phase_next = PH_KEY_STR;
            end else begin
              fl = 1'b1;
            end
          end
        end
        PH_COLON: begin
          if (!is_ws(c)) begin
            if (c == CH_COLON) begin
              phase_next = PH_VALUE;
            end else begin
              fl = 1'b1;
            end
          end
        end
        PH_AFTER: av = 1'b1;
        PH_STR, PH_KEY_STR: begin
          if (c == CH_BSLASH) begin
            phase_next = (phase == PH_STR) ? PH_STR_ESC : PH_KEY_ESC;
          end else if (c == CH_QUOTE) begin
            phase_next = (phase == PH_STR) ? PH_AFTER : PH_COLON;
          end else if (c < CH_CTRL) begin
            fl = 1'b1;
          end
        end
        PH_STR_ESC: phase_next = PH_STR;
        PH_KEY_ESC: phase_next = PH_KEY_STR;
        PH_LIT: begin
          if (lit_kind == LIT_NONE || lit_idx >= lit_len(lit_kind) ||
              c != lit_char(lit_kind, lit_idx)) begin
            fl = 1'b1;
          end else if (lit_idx == lit_len(lit_kind) - 3'd1) begin
            lit_idx_next  = 3'd0;
            lit_kind_next = LIT_TRUE;
            phase_next    = PH_AFTER;
          end else begin
            lit_idx_next = lit_idx + 3'd1;
          end
        end
        PH_NUM_SIGN: begin
          if (c == "0") begin
            phase_next = PH_NUM_ZERO;
          end else if (is_digit(c)) begin
            phase_next = PH_NUM_INT;
          end else begin
            fl = 1'b1;
          end
        end
        PH_NUM_ZERO, PH_NUM_INT: begin
          if (phase == PH_NUM_INT && is_digit(c)) begin
            phase_next = PH_NUM_INT;
          end else if (c == CH_DOT) begin
            phase_next = PH_NUM_DOT;
          end else if (is_e(c)) begin
            phase_next = PH_NUM_E;
          end else begin
            av = 1'b1;
          end
        end
        PH_NUM_DOT: begin
          if (is_digit(c)) begin
            phase_next = PH_NUM_FRAC;
          end else begin
            fl = 1'b1;
          end
        end
        PH_NUM_FRAC: begin
          if (is_e(c)) begin
            phase_next = PH_NUM_E;
          end else if (!is_digit(c)) begin
            av = 1'b1;
          end
        end
        PH_NUM_E: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            phase_next = PH_NUM_ESIGN;
          end else if (is_digit(c)) begin
            phase_next = PH_NUM_EXP;
          end else begin
            fl = 1'b1;
          end
        end
        PH_NUM_ESIGN: begin
          if (is_digit(c)) begin
            phase_next = PH_NUM_EXP;
          end else begin
            fl = 1'b1;
          end
        end
        PH_NUM_EXP: begin
          if (!is_digit(c)) begin
            av = 1'b1;
          end
        end
        default: fl = 1'b1;
      endcase

      // Start of a value
      if (sv && !is_ws(c)) begin
        case (c)
          CH_QUOTE: phase_next = PH_STR;
          "t": begin
            phase_next    = PH_LIT;
            lit_kind_next = LIT_TRUE;
            lit_idx_next  = 3'd1;
          end
          "f": begin
            phase_next    = PH_LIT;
            lit_kind_next = LIT_FALSE;
            lit_idx_next  = 3'd1;
          end
          "n": begin
            phase_next    = PH_LIT;
            lit_kind_next = LIT_NULL;
            lit_idx_next  = 3'd1;
          end
          CH_MINUS: phase_next = PH_NUM_SIGN;
          "0":      phase_next = PH_NUM_ZERO;
          CH_LBRACK, CH_LBRACE: begin
            if (stat.full) begin
              overflow_seen_next = 1'b1;
              fl                 = 1'b1;
            end else begin
              op.push    = 1'b1;
              op.kind    = (c == CH_LBRACE) ? jsc_pkg::KIND_OBJECT : jsc_pkg::KIND_ARRAY;
              phase_next = (c == CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
            end
          end
          default: begin
            if (is_digit(c)) begin
              phase_next = PH_NUM_INT;
            end else begin
              fl = 1'b1;
            end
          end
        endcase
      end

      // Separator or closer after a finished value
      if (av) begin
        phase_next = PH_AFTER;
        if (!is_ws(c)) begin
          if (stat.zero) begin
            fl = 1'b1;
          end else if (c == CH_COMMA) begin
            phase_next = (stat.top_kind == jsc_pkg::KIND_OBJECT) ? PH_KEY : PH_VALUE;
          end else if (c == CH_RBRACK && stat.top_kind == jsc_pkg::KIND_ARRAY) begin
            op.pop = 1'b1;
          end else if (c == CH_RBRACE && stat.top_kind == jsc_pkg::KIND_OBJECT) begin
            op.pop = 1'b1;
          end else begin
            fl = 1'b1;
          end
        end
      end

      if (fl) begin
        error_seen_next = 1'b1;
      end
    end

    // End of document: report, then drop all state
    if (take && word.end_of_doc) begin
      done_ph = (phase_next == PH_AFTER) || (phase_next == PH_NUM_ZERO) ||
                (phase_next == PH_NUM_INT) || (phase_next == PH_NUM_FRAC) ||
                (phase_next == PH_NUM_EXP);
      empty_after = (stat.zero && !op.push) || (stat.one && op.pop);
      res_valid          = 1'b1;
      res.valid_res      = !error_seen_next && !overflow_seen_next && done_ph && empty_after;
      res.depth_exceeded = overflow_seen_next;
      phase_next         = PH_VALUE;
      lit_kind_next      = LIT_TRUE;
      lit_idx_next       = 3'd0;
      error_seen_next    = 1'b0;
      overflow_seen_next = 1'b0;
      op.push            = 1'b0;
      op.pop             = 1'b0;
      op.clear           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_VALUE;
      lit_kind      <= LIT_TRUE;
      lit_idx       <= 3'd0;
      error_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      lit_kind      <= lit_kind_next;
      lit_idx       <= lit_idx_next;
      error_seen    <= error_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

@@ sv/json_syntax_checker.sv @@
// The result word appears on res_word in the cycle after the word that ends the document.
// Throughput: one input word per cycle while byte_stall is low; the phase update and the stack
// top access both finish in that cycle, the entry under the top being prefetched from the stack memory.
// The input stalls only for an end-of-document word while an earlier result is still stalled.
// Reset clears the parse phase, the nesting level, the error flags and the result valid flag;
// the stack memory is not cleared, since only entries that were pushed are ever used.
module json_syntax_checker #(
  parameter int MAX_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  jsc_pkg::in_word_t  byte_word,
  output logic               res_valid,
  input  logic               res_stall,
  output jsc_pkg::out_word_t res_word
);

  jsc_pkg::stack_op_t   op;
  jsc_pkg::stack_stat_t stat;
  logic                 take;
  logic                 done;
  jsc_pkg::out_word_t   done_word;

  // Hold an end word only when the result register is full and stalled;
  // every other word keeps flowing while a result waits.
  assign byte_stall = res_valid && res_stall && byte_word.end_of_doc;
  assign take       = byte_valid && !byte_stall;

  // Parse state machine: one word per cycle while the input is not stalled
  jsc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (byte_word),
    .stat      (stat),
    .op        (op),
    .res_valid (done),
    .res       (done_word)
  );

  // Nesting stack: memory plus top-of-stack register
  jsc_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .stat (stat)
  );

  // Result register: load on end of document, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_word <= done_word;
    end
  end

endmodule
